FILE: rtl/core/erfe_pkg.sv
// Shared types and constants for the echo range frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package erfe_pkg;

   // Echo widths at or above this tick count are over-range
   localparam logic [15:0] TICK_LIMIT = 16'd46400;

   // mm = (us * 5) / 29, taken as a reciprocal multiply plus one correction
   localparam logic [15:0] RECIP_MM   = 16'd36157;   // floor(2^20 / 29)
   localparam int          RECIP_MM_SHIFT = 20;
   localparam logic [4:0]  MM_DIV     = 5'd29;

   // Reciprocals for the decimal split and the servo scale
   localparam logic [12:0] RECIP_TEN  = 13'd6554;    // mm / 10, shift 16
   localparam logic [5:0]  RECIP_HUND = 6'd41;       // cm / 100, shift 12
   localparam logic [7:0]  RECIP_CM10 = 8'd205;      // cm / 10, shift 11
   localparam logic [16:0] RECIP_DUTY = 17'd120589;  // cm * 23 / 400, shift 21
   localparam logic [7:0]  DUTY_BASE  = 8'd35;

   // Indicator colours
   localparam logic [1:0] IND_GREEN = 2'd0;
   localparam logic [1:0] IND_RED   = 2'd1;
   localparam logic [1:0] IND_BLUE  = 2'd2;

   // Frame characters
   localparam logic [7:0] CH_OPEN  = 8'h3C;   // '<'
   localparam logic [7:0] CH_CLOSE = 8'h3E;   // '>'
   localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] CH_NONE  = 8'h00;

   // Character positions within a frame
   localparam logic [2:0] POS_OPEN  = 3'd0;
   localparam logic [2:0] POS_HUND  = 3'd1;
   localparam logic [2:0] POS_TENS  = 3'd2;
   localparam logic [2:0] POS_UNITS = 3'd3;
   localparam logic [2:0] POS_TENTH = 3'd4;
   localparam logic [2:0] POS_CLOSE = 3'd5;

   // Scaled measurement leaving the front half of the pipeline
   typedef struct packed {
      logic        over;
      logic [11:0] mm;
   } scale_type;

   // Everything the serialiser needs for one frame
   typedef struct packed {
      logic       over;
      logic [8:0] cm;
      logic [3:0] tenths;
      logic [7:0] duty;
      logic [1:0] ind;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
      logic [2:0] first;
   } frame_type;

endpackage

`default_nettype wire

FILE: rtl/core/echo_range_frame_encoder.sv
// Top level of the echo range frame encoder.
//
// Request channel (req_): one echo measurement per request, the echo width
// in half-microsecond ticks in tdata and the over-range flag in tuser.
// Response channel (rsp_): one response per frame character '<', the
// distance digits with leading zeros dropped, then '>'; tlast marks the
// last response of a measurement. An over-range request gives a single
// response with no character and the blue indicator.
// Configuration channel (csr_): writes the green/red threshold in cm; it
// is always ready. It must be written only while the block is idle; the
// block itself does not enforce this. Each request passes through a
// six-stage arithmetic pipeline and then the serialiser. A request may
// be accepted every cycle while the pipeline is not stalled; sustained,
// the serialiser paces it, one character a cycle while rsp_tready is high.
// Reset clears all pipeline valid bits and sets the threshold to 1 cm.
// A stalled response holds; the pipeline fills behind it and then drops
// req_tready, with nothing lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module echo_range_frame_encoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,    // [15:0] echo_ticks
   input  wire         req_tuser,    // [0] over_range
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] frame_char, [16:8] distance_cm,
                                     // [20:17] tenths, [28:21] servo_duty,
                                     // [30:29] indicator, [31] zero
   output logic [1:0]  rsp_tuser,    // [0] char_valid, [1] range_error
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [8:0]  csr_wdata     // local_min_cm
);
   import erfe_pkg::*;

   logic      [8:0] local_min_ff;
   logic            sc_valid, sc_ready;
   scale_type       sc_data;
   logic            fr_valid, fr_ready;
   frame_type       fr_data;

   // Threshold register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_min_ff <= 9'd1;
      end else if (csr_valid) begin
         local_min_ff <= csr_wdata;
      end
   end

   erfe_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ticks  (req_tdata),
      .in_over   (req_tuser),
      .out_valid (sc_valid),
      .out_ready (sc_ready),
      .out_data  (sc_data)
   );

   erfe_digits u_digits (
      .clock        (clock),
      .reset        (reset),
      .local_min_cm (local_min_ff),
      .in_valid     (sc_valid),
      .in_ready     (sc_ready),
      .in_data      (sc_data),
      .out_valid    (fr_valid),
      .out_ready    (fr_ready),
      .out_data     (fr_data)
   );

   erfe_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (fr_valid),
      .in_ready   (fr_ready),
      .in_data    (fr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/core/erfe_scale.sv
// Front pipeline: tick halving, over-range test and scaling to millimetres.
`timescale 1ns / 1ps
`default_nettype none

module erfe_scale (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  wire  [15:0]            in_ticks,
   input  wire                    in_over,
   output logic                   out_valid,
   input  wire                    out_ready,
   output erfe_pkg::scale_type    out_data
);
   import erfe_pkg::*;

   logic        en1, en2, en3;
   logic        s1_v_ff, s2_v_ff, s3_v_ff;
   logic        s1_ov_ff, s2_ov_ff, s3_ov_ff;
   logic [17:0] s1_x_ff, s2_x_ff;
   logic [11:0] s2_q_ff, s3_mm_ff;
   logic [17:0] s1_x_in;
   logic        s1_ov_in;
   logic [33:0] prod;
   logic [11:0] s2_q_in;
   logic [17:0] rem;
   logic [11:0] s3_mm_in;

   // Stage enables: a stage moves when it is empty or its successor moves
   always_comb begin
      en3      = !s3_v_ff || out_ready;
      en2      = !s2_v_ff || en3;
      en1      = !s1_v_ff || en2;
      in_ready = en1;
   end

   // Stage 1: microseconds times five, over-range flag
   always_comb begin
      s1_x_in  = ({3'b0, in_ticks[15:1]} << 2) + {3'b0, in_ticks[15:1]};
      s1_ov_in = in_over || (in_ticks >= TICK_LIMIT);
   end

   // Stage 2: reciprocal estimate, at most one low
   always_comb begin
      prod    = 34'(s1_x_ff) * 34'(RECIP_MM);
      s2_q_in = prod[RECIP_MM_SHIFT +: 12];
   end

   // Stage 3: remainder check and correction
   always_comb begin
      rem      = s2_x_ff - 18'(s2_q_ff) * 18'(MM_DIV);
      s3_mm_in = (rem >= 18'(MM_DIV)) ? s2_q_ff + 12'd1 : s2_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (en1) s1_v_ff <= in_valid;
         if (en2) s2_v_ff <= s1_v_ff;
         if (en3) s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_x_ff  <= s1_x_in;
         s1_ov_ff <= s1_ov_in;
      end
      if (en2) begin
         s2_x_ff  <= s1_x_ff;
         s2_q_ff  <= s2_q_in;
         s2_ov_ff <= s1_ov_ff;
      end
      if (en3) begin
         s3_mm_ff <= s3_mm_in;
         s3_ov_ff <= s2_ov_ff;
      end
   end

   assign out_valid     = s3_v_ff;
   assign out_data.over = s3_ov_ff;
   assign out_data.mm   = s3_mm_ff;

endmodule

`default_nettype wire

FILE: rtl/core/erfe_digits.sv
// Back pipeline: centimetres, tenths, digits, servo duty and indicator.
`timescale 1ns / 1ps
`default_nettype none

module erfe_digits (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [8:0]             local_min_cm,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  erfe_pkg::scale_type    in_data,
   output logic                   out_valid,
   input  wire                    out_ready,
   output erfe_pkg::frame_type    out_data
);
   import erfe_pkg::*;

   logic        en4, en5, en6;
   logic        s4_v_ff, s5_v_ff, s6_v_ff;
   logic        s4_ov_ff, s5_ov_ff;
   logic [11:0] s4_mm_ff;
   logic [8:0]  s4_cm_ff, s5_cm_ff;
   logic [3:0]  s5_tn_ff;
   logic [1:0]  s5_hund_ff;
   logic [5:0]  s5_cm10_ff;
   logic [7:0]  s5_duty_ff;
   logic [1:0]  s5_ind_ff;
   frame_type   s6_ff;
   logic [24:0] p_ten;
   logic [8:0]  s4_cm_in;
   logic [11:0] tn_wide;
   logic [13:0] p_hund;
   logic [16:0] p_cm10;
   logic [25:0] p_duty;
   logic [7:0]  s5_duty_in;
   logic [1:0]  s5_ind_in;
   logic [8:0]  tens_wide, units_wide;
   logic [3:0]  hund_d, tens_d, units_d;
   frame_type   s6_in;

   always_comb begin
      en6      = !s6_v_ff || out_ready;
      en5      = !s5_v_ff || en6;
      en4      = !s4_v_ff || en5;
      in_ready = en4;
   end

   // Stage 4: whole centimetres
   always_comb begin
      p_ten    = 25'(in_data.mm) * 25'(RECIP_TEN);
      s4_cm_in = p_ten[24:16];
   end

   // Stage 5: tenths, hundreds, cm/10, servo duty, indicator
   always_comb begin
      tn_wide    = s4_mm_ff - 12'(s4_cm_ff) * 12'd10;
      p_hund     = 14'(s4_cm_ff) * 14'(RECIP_HUND);
      p_cm10     = 17'(s4_cm_ff) * 17'(RECIP_CM10);
      p_duty     = 26'(s4_cm_ff) * 26'(RECIP_DUTY);
      s5_duty_in = DUTY_BASE - {3'b0, p_duty[25:21]};
      s5_ind_in  = (s4_cm_ff >= local_min_cm) ? IND_GREEN : IND_RED;
   end

   // Stage 6: tens and units, first shown digit, over-range masking
   always_comb begin
      hund_d     = {2'b0, s5_hund_ff};
      tens_wide  = {3'b0, s5_cm10_ff} - 9'(s5_hund_ff) * 9'd10;
      units_wide = s5_cm_ff - 9'(s5_cm10_ff) * 9'd10;
      tens_d     = tens_wide[3:0];
      units_d    = units_wide[3:0];

      s6_in.over   = s5_ov_ff;
      s6_in.hund   = hund_d;
      s6_in.tens   = tens_d;
      s6_in.units  = units_d;
      if (hund_d != 4'd0) begin
         s6_in.first = POS_HUND;
      end else if (tens_d != 4'd0) begin
         s6_in.first = POS_TENS;
      end else if (units_d != 4'd0) begin
         s6_in.first = POS_UNITS;
      end else if (s5_tn_ff != 4'd0) begin
         s6_in.first = POS_TENTH;
      end else begin
         s6_in.first = POS_CLOSE;
      end

      if (s5_ov_ff) begin
         s6_in.cm     = 9'd0;
         s6_in.tenths = 4'd0;
         s6_in.duty   = 8'd0;
         s6_in.ind    = IND_BLUE;
      end else begin
         s6_in.cm     = s5_cm_ff;
         s6_in.tenths = s5_tn_ff;
         s6_in.duty   = s5_duty_ff;
         s6_in.ind    = s5_ind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         if (en4) s4_v_ff <= in_valid;
         if (en5) s5_v_ff <= s4_v_ff;
         if (en6) s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_ov_ff <= in_data.over;
         s4_mm_ff <= in_data.mm;
         s4_cm_ff <= s4_cm_in;
      end
      if (en5) begin
         s5_ov_ff   <= s4_ov_ff;
         s5_cm_ff   <= s4_cm_ff;
         s5_tn_ff   <= tn_wide[3:0];
         s5_hund_ff <= p_hund[13:12];
         s5_cm10_ff <= p_cm10[16:11];
         s5_duty_ff <= s5_duty_in;
         s5_ind_ff  <= s5_ind_in;
      end
      if (en6) begin
         s6_ff <= s6_in;
      end
   end

   assign out_valid = s6_v_ff;
   assign out_data  = s6_ff;

endmodule

`default_nettype wire

FILE: rtl/core/erfe_serial.sv
// Frame serialiser: sends one frame character per response.
`timescale 1ns / 1ps
`default_nettype none

module erfe_serial (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  erfe_pkg::frame_type    in_data,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [31:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);
   import erfe_pkg::*;

   logic       valid_ff;
   logic [2:0] pos_ff;
   frame_type  frame_ff;
   logic       is_last;
   logic       load;
   logic       step;
   logic [7:0] ch;
   logic [2:0] pos_in;

   // Current character and end of frame
   always_comb begin
      is_last = frame_ff.over || (pos_ff == POS_CLOSE);
      case (pos_ff)
         POS_OPEN:  ch = CH_OPEN;
         POS_HUND:  ch = CH_ZERO + {4'b0, frame_ff.hund};
         POS_TENS:  ch = CH_ZERO + {4'b0, frame_ff.tens};
         POS_UNITS: ch = CH_ZERO + {4'b0, frame_ff.units};
         POS_TENTH: ch = CH_ZERO + {4'b0, frame_ff.tenths};
         POS_CLOSE: ch = CH_CLOSE;
         default:   ch = CH_NONE;
      endcase
      if (frame_ff.over) ch = CH_NONE;
   end

   // A new frame loads when the holder is empty or sends its last character
   always_comb begin
      step     = valid_ff && rsp_tready;
      in_ready = !valid_ff || (rsp_tready && is_last);
      load     = in_valid && in_ready;
      pos_in   = (pos_ff == POS_OPEN) ? frame_ff.first : pos_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= POS_OPEN;
      end else if (load) begin
         valid_ff <= 1'b1;
         pos_ff   <= POS_OPEN;
      end else if (step) begin
         if (is_last) begin
            valid_ff <= 1'b0;
         end else begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) frame_ff <= in_data;
   end

   // Response fields
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = is_last;
   assign rsp_tuser  = {frame_ff.over, !frame_ff.over};
   assign rsp_tdata  = {1'b0, frame_ff.ind, frame_ff.duty, frame_ff.tenths,
                        frame_ff.cm, ch};

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the echo range frame encoder: random and directed echo requests.
`timescale 1ns / 1ps

module tb_top;
   import erfe_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;
   localparam int HOLD_CYCLES = 300;

   // One echo measurement as offered on the request channel
   typedef struct packed {
      logic [15:0] ticks;
      logic        over;
   } echo_req_type;

   // One frame character response, field by field
   typedef struct packed {
      logic       char_valid;
      logic [7:0] frame_char;
      logic       last;
      logic [8:0] distance_cm;
      logic [3:0] tenths;
      logic [7:0] servo_duty;
      logic [1:0] indicator;
      logic       range_error;
   } echo_char_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] echo_ticks
   logic        req_tuser  = 1'b0; // [0] over_range
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [7:0] frame_char, [16:8] distance_cm, [20:17] tenths,
                                   // [28:21] servo_duty, [30:29] indicator
   logic [1:0]  rsp_tuser;         // [0] char_valid, [1] range_error
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_wdata  = '0;

   echo_req_type   echo_backlog[$];
   echo_char_type  chars_due[$];
   logic [8:0]  local_min      = 9'd1;
   int          req_idle_pct   = 0;
   int          rsp_stall_pct  = 0;
   int          hold_goal      = 0;
   int          hold_count     = 0;
   int          faults         = 0;
   int          cycle_count    = 0;
   logic        req_fire_q     = 1'b0;

   echo_range_frame_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Work out the frame characters one echo request should produce
   function automatic void encode_echo(input logic [15:0] ticks, input logic over);
      int unsigned    us, mm, cm, tn, duty;
      logic [7:0]     digits [6];
      logic [1:0]     ind;
      int             pos;
      echo_char_type  c;
      if (over || ticks >= TICK_LIMIT) begin
         c = '0;
         c.last        = 1'b1;
         c.indicator   = IND_BLUE;
         c.range_error = 1'b1;
         chars_due.push_back(c);
         return;
      end
      us   = ticks / 2;
      mm   = (us * 10) / 58;
      cm   = mm / 10;
      tn   = mm % 10;
      duty = 35 - (cm * 23) / 400;
      ind  = (cm >= local_min) ? IND_GREEN : IND_RED;
      digits[0] = CH_OPEN;
      digits[1] = CH_ZERO + 8'((cm / 100) % 10);
      digits[2] = CH_ZERO + 8'((cm / 10) % 10);
      digits[3] = CH_ZERO + 8'(cm % 10);
      digits[4] = CH_ZERO + 8'(tn);
      digits[5] = CH_CLOSE;
      c.char_valid  = 1'b1;
      c.distance_cm = 9'(cm);
      c.tenths      = 4'(tn);
      c.servo_duty  = 8'(duty);
      c.indicator   = ind;
      c.range_error = 1'b0;
      c.frame_char  = digits[0];
      c.last        = 1'b0;
      chars_due.push_back(c);
      // leading zeros dropped; an all-zero distance leaves just the brackets
      pos = 1;
      while (pos < 5 && digits[pos] == CH_ZERO)
         pos++;
      for (; pos < 6; pos++) begin
         c.frame_char = digits[pos];
         c.last       = (pos == 5);
         chars_due.push_back(c);
      end
   endfunction

   // Random echo request, weighted towards valid widths and the threshold
   function automatic echo_req_type pick_echo();
      echo_req_type  r;
      int unsigned   roll, near_cm;
      roll   = $urandom_range(99);
      r.over = 1'b0;
      r.ticks = 16'($urandom_range(46399));
      if (roll < 8) begin
         r.over  = 1'b1;
         r.ticks = 16'($urandom);
      end else if (roll < 16) begin
         r.ticks = 16'($urandom_range(65535, 46400));
      end else if (roll < 30) begin
         r.ticks = 16'($urandom_range(200));
      end else if (roll < 42) begin
         near_cm = (local_min > 399) ? 399 : local_min;
         near_cm = near_cm + $urandom_range(4);
         near_cm = (near_cm < 2) ? 0 : near_cm - 2;
         r.ticks = 16'(near_cm * 116 + $urandom_range(115));
         if (r.ticks >= TICK_LIMIT)
            r.ticks = TICK_LIMIT - 16'd1;
      end
      return r;
   endfunction

   task automatic queue_echo(input logic [15:0] ticks, input logic over);
      echo_backlog.push_back('{ticks: ticks, over: over});
   endtask

   // Checked on rising edges, where the driver's outputs are settled
   task automatic wait_drained();
      while (echo_backlog.size() != 0 || req_tvalid || chars_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_threshold(input logic [8:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      local_min = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Start a phase on a rising edge so the driver sees it cleanly
   task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
      @(posedge clock);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count)
         echo_backlog.push_back(pick_echo());
      wait_drained();
   endtask

   // Request driver: holds an item until it is taken, then maybe idles
   always @(negedge clock) begin
      echo_req_type item;
      if (req_fire_q || !req_tvalid) begin
         if (echo_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            item = echo_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.ticks;
            req_tuser  <= item.over;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response ready: one long hold-off on request, otherwise random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_count < hold_goal) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      echo_char_type got, want;
      req_fire_q <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready)
         encode_echo(req_tdata, req_tuser);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.char_valid  = rsp_tuser[0];
         got.frame_char  = rsp_tdata[7:0];
         got.last        = rsp_tlast;
         got.distance_cm = rsp_tdata[16:8];
         got.tenths      = rsp_tdata[20:17];
         got.servo_duty  = rsp_tdata[28:21];
         got.indicator   = rsp_tdata[30:29];
         got.range_error = rsp_tuser[1];
         if (chars_due.size() == 0) begin
            faults++;
            if (faults <= REPORT_MAX)
               $display("unexpected response: ch=%h cm=%0d tn=%0d", got.frame_char,
                        got.distance_cm, got.tenths);
         end else begin
            want = chars_due.pop_front();
            if (got !== want) begin
               faults++;
               if (faults <= REPORT_MAX) begin
                  $display({"mismatch exp: v=%0d ch=%h last=%0d cm=%0d tn=%0d",
                            " duty=%0d ind=%0d err=%0d"},
                           want.char_valid, want.frame_char, want.last, want.distance_cm,
                           want.tenths, want.servo_duty, want.indicator, want.range_error);
                  $display({"         got: v=%0d ch=%h last=%0d cm=%0d tn=%0d",
                            " duty=%0d ind=%0d err=%0d"},
                           got.char_valid, got.frame_char, got.last, got.distance_cm,
                           got.tenths, got.servo_duty, got.indicator, got.range_error);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: threshold left at its reset value of 1 cm
      @(posedge clock);
      queue_echo(16'd0, 1'b0);       // zero distance, brackets only
      queue_echo(16'd1, 1'b0);
      queue_echo(16'd12, 1'b0);      // tenths digit alone
      queue_echo(16'd115, 1'b0);     // just under threshold, red
      queue_echo(16'd116, 1'b0);     // exactly 1.0 cm, green
      queue_echo(16'd1160, 1'b0);    // 10.0 cm
      queue_echo(16'd11600, 1'b0);   // 100.0 cm, full six-character frame
      queue_echo(16'd23200, 1'b0);
      queue_echo(16'd12345, 1'b0);
      queue_echo(16'd46399, 1'b0);   // largest in-range width
      queue_echo(16'd46400, 1'b0);   // first over-range width
      queue_echo(16'd65535, 1'b0);
      queue_echo(16'd0, 1'b1);       // timer expiry flag
      queue_echo(16'd46399, 1'b1);   // flag wins over a valid width
      queue_echo(16'd65535, 1'b1);
      queue_echo(16'd43690, 1'b0);
      queue_echo(16'd21845, 1'b0);
      wait_drained();

      write_threshold(9'd0);
      run_phase(100, 0, 0);
      write_threshold(9'd511);
      run_phase(90, 56, 0);
      write_threshold(9'd400);
      run_phase(90, 0, 56);
      write_threshold(9'($urandom_range(399)));
      run_phase(90, 26, 26);

      // Back-pressure: long receiver hold while requests keep coming
      write_threshold(9'($urandom_range(400)));
      @(posedge clock);
      hold_goal = HOLD_CYCLES;
      run_phase(40, 0, 0);

      repeat (20) @(posedge clock);
      if (faults == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
